FILE: design/assert_macros.svh
// Shared assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge unless rst is high.
`define CHK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checks that an expression is never true while rst is low.
`define CHK_NEVER(lbl, clk, rst, expr) \
   `CHK_ASSERT(lbl, clk, rst, !(expr))

`endif

FILE: design/c1d_pkg.sv
package c1d_pkg;

   localparam int DEF_MAX_TAPS = 7;
   localparam int DEF_MAX_IN   = 8;
   localparam int DEF_MAX_OUT  = 8;

   localparam logic [1:0] ACT_WEIGHT = 2'd0;
   localparam logic [1:0] ACT_BIAS   = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   localparam logic [1:0] CSR_TAPS = 2'd0;
   localparam logic [1:0] CSR_ICNT = 2'd1;
   localparam logic [1:0] CSR_OCNT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ISSUE,
      ST_DRAIN,
      ST_OUT,
      ST_ADVANCE
   } state_type;

   typedef struct packed {
      logic ld_weight;
      logic ld_bias;
      logic wr_sample;
      logic issue;
      logic first;
      logic advance;
      logic clear_all;
      logic load_out;
      logic pos_last;
      logic run_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

FILE: design/c1d_ram.sv
module c1d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/c1d_dpath.sv
module c1d_dpath import c1d_pkg::*; #(
   parameter int MAX_TAPS = DEF_MAX_TAPS,
   parameter int MAX_IN   = DEF_MAX_IN,
   parameter int MAX_OUT  = DEF_MAX_OUT,
   localparam int RW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
   localparam int CW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
   localparam int FW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [2:0]         req_tap_index,
   input  logic [2:0]         req_in_chan,
   input  logic [2:0]         req_out_chan,
   input  logic signed [15:0] req_sample_value,
   input  logic [RW-1:0]      iss_tap,
   input  logic [RW-1:0]      iss_row,
   input  logic [CW-1:0]      iss_chan,
   input  logic [FW-1:0]      iss_filt,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_filter_index,
   output logic [14:0]        rsp_result_value,
   output logic               rsp_position_last,
   output logic               rsp_run_last
);

   localparam int HD    = MAX_TAPS * MAX_IN;
   localparam int HAW   = (HD > 1) ? $clog2(HD) : 1;
   localparam int WD    = HD * MAX_OUT;
   localparam int WAW   = (WD > 1) ? $clog2(WD) : 1;
   localparam int ACC_W = 33 + $clog2(HD + 1);

   logic [RW-1:0]  base_ff, base_in;
   logic [HD-1:0]  valid_ff, valid_in;
   logic [HAW-1:0] h_wr_addr, h_rd_addr;
   logic [WAW-1:0] w_wr_addr, w_rd_addr;
   logic [FW-1:0]  b_wr_addr;
   logic           w_ok, b_ok;
   logic [RW:0]    phys_sum;
   logic [RW-1:0]  phys;
   logic [15:0]    h_rd, w_rd, b_rd;
   logic           s1_valid_ff, s1_first_ff, s1_hv_ff;
   logic           s2_valid_ff, s2_first_ff;
   logic [15:0]    bias_ff;
   logic signed [15:0] hsel;
   logic signed [31:0] prod_ff, prod_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [14:0]    value;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     filt_ff;
   logic [14:0]    value_ff;
   logic           pos_last_ff, run_last_ff;

   assign w_ok = (int'(req_tap_index) < MAX_TAPS) && (int'(req_in_chan) < MAX_IN)
                 && (int'(req_out_chan) < MAX_OUT);
   assign b_ok = int'(req_out_chan) < MAX_OUT;
   assign w_wr_addr = WAW'((int'(req_tap_index) * MAX_IN + int'(req_in_chan)) * MAX_OUT
                           + int'(req_out_chan));
   assign w_rd_addr = WAW'((int'(iss_tap) * MAX_IN + int'(iss_chan)) * MAX_OUT
                           + int'(iss_filt));
   assign b_wr_addr = FW'(req_out_chan);
   assign h_wr_addr = HAW'(int'(base_ff) * MAX_IN + int'(req_in_chan));

   // Row 0 sits at base_ff; older rows follow it around the ring.
   assign phys_sum  = {1'b0, base_ff} + {1'b0, iss_row};
   assign phys      = (int'(phys_sum) >= MAX_TAPS) ? RW'(int'(phys_sum) - MAX_TAPS)
                                                   : phys_sum[RW-1:0];
   assign h_rd_addr = HAW'(int'(phys) * MAX_IN + int'(iss_chan));

   c1d_ram #(.WIDTH(16), .DEPTH(WD)) u_weight (
      .clock(clock), .wr_en(cmd.ld_weight && w_ok), .wr_addr(w_wr_addr),
      .wr_data(req_sample_value), .rd_en(cmd.issue), .rd_addr(w_rd_addr), .rd_data(w_rd)
   );

   c1d_ram #(.WIDTH(16), .DEPTH(MAX_OUT)) u_bias (
      .clock(clock), .wr_en(cmd.ld_bias && b_ok), .wr_addr(b_wr_addr),
      .wr_data(req_sample_value), .rd_en(cmd.issue), .rd_addr(iss_filt), .rd_data(b_rd)
   );

   c1d_ram #(.WIDTH(16), .DEPTH(HD)) u_hist (
      .clock(clock), .wr_en(cmd.wr_sample), .wr_addr(h_wr_addr),
      .wr_data(req_sample_value), .rd_en(cmd.issue), .rd_addr(h_rd_addr), .rd_data(h_rd)
   );

   always_comb begin
      base_in  = base_ff;
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.advance) begin
         base_in = (base_ff == '0) ? RW'(MAX_TAPS - 1) : base_ff - RW'(1);
         for (int i = 0; i < MAX_IN; i++) begin
            valid_in[int'(base_in) * MAX_IN + i] = 1'b0;
         end
      end else if (cmd.wr_sample) begin
         valid_in[h_wr_addr] = 1'b1;
      end
   end

   assign hsel    = s1_hv_ff ? $signed(h_rd) : 16'sd0;
   assign prod_in = hsel * $signed(w_rd);

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         acc_in = (s2_first_ff ? {{(ACC_W - 28){bias_ff[15]}}, bias_ff, 12'b0} : acc_ff)
                  + {{(ACC_W - 32){prod_ff[31]}}, prod_ff};
      end
   end

   always_comb begin
      if (acc_ff[ACC_W-1] || acc_ff == '0) begin
         value = '0;
      end else if (|acc_ff[ACC_W-1:27]) begin
         value = 15'h7fff;
      end else begin
         value = acc_ff[26:12];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         valid_ff     <= valid_in;
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_hv_ff    <= valid_ff[h_rd_addr];
      s2_first_ff <= s1_first_ff;
      prod_ff     <= prod_in;
      if (s1_valid_ff && s1_first_ff) begin
         bias_ff <= b_rd;
      end
      acc_ff <= acc_in;
      if (cmd.load_out) begin
         filt_ff     <= 3'(iss_filt);
         value_ff    <= value;
         pos_last_ff <= cmd.pos_last;
         run_last_ff <= cmd.run_last;
      end
   end

   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filter_index  = filt_ff;
   assign rsp_result_value  = value_ff;
   assign rsp_position_last = pos_last_ff;
   assign rsp_run_last      = run_last_ff;

endmodule

FILE: design/c1d_ctrl.sv
module c1d_ctrl import c1d_pkg::*; #(
   parameter int MAX_TAPS = DEF_MAX_TAPS,
   parameter int MAX_IN   = DEF_MAX_IN,
   parameter int MAX_OUT  = DEF_MAX_OUT,
   localparam int RW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
   localparam int CW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
   localparam int FW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_action,
   input  logic [2:0]    req_in_chan,
   input  logic          req_sequence_end,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [3:0]    csr_data,
   output cmd_type       cmd,
   input  status_type    status,
   output logic [RW-1:0] iss_tap,
   output logic [RW-1:0] iss_row,
   output logic [CW-1:0] iss_chan,
   output logic [FW-1:0] iss_filt
);

   localparam int ICW = $clog2(MAX_IN + 1);
   localparam int OCW = $clog2(MAX_OUT + 1);

   state_type      state_ff, state_in;
   logic [2:0]     tap_reg_ff;
   logic [3:0]     icnt_reg_ff, ocnt_reg_ff;
   logic [2:0]     seen_ff, seen_in;
   logic [3:0]     remain_ff, remain_in;
   logic           end_ff, end_in;
   logic [RW-1:0]  t_ff, t_in;
   logic [CW-1:0]  c_ff, c_in;
   logic [FW-1:0]  f_ff, f_in;
   logic           drain_ff, drain_in;
   logic [2:0]     taps, look;
   logic [ICW-1:0] ic;
   logic [OCW-1:0] oc;
   logic           accept, pos_last;

   // Counts outside their legal range are pulled back in when used.
   always_comb begin
      if (tap_reg_ff == '0) taps = 3'd1;
      else if (int'(tap_reg_ff) > MAX_TAPS) taps = 3'(MAX_TAPS);
      else taps = tap_reg_ff;
      if (icnt_reg_ff == '0) ic = ICW'(1);
      else if (int'(icnt_reg_ff) > MAX_IN) ic = ICW'(MAX_IN);
      else ic = ICW'(icnt_reg_ff);
      if (ocnt_reg_ff == '0) oc = OCW'(1);
      else if (int'(ocnt_reg_ff) > MAX_OUT) oc = OCW'(MAX_OUT);
      else oc = OCW'(ocnt_reg_ff);
   end

   assign look      = 3'((int'(taps) - 1) - ((int'(taps) - 1) >> 1));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign pos_last  = (int'(f_ff) + 1 == int'(oc));

   assign iss_tap  = t_ff;
   assign iss_row  = RW'(int'(taps) - 1 - int'(t_ff));
   assign iss_chan = c_ff;
   assign iss_filt = f_ff;

   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      remain_in = remain_ff;
      end_in    = end_ff;
      t_in      = t_ff;
      c_in      = c_ff;
      f_in      = f_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_WEIGHT: cmd.ld_weight = 1'b1;
                  ACT_BIAS:   cmd.ld_bias = 1'b1;
                  ACT_SAMPLE: begin
                     if (int'(req_in_chan) < int'(ic)) begin
                        cmd.wr_sample = 1'b1;
                        if (int'(req_in_chan) + 1 == int'(ic) || req_sequence_end) begin
                           remain_in = req_sequence_end ? 4'({1'b0, look}) + 4'd1 : 4'd1;
                           end_in    = req_sequence_end;
                           state_in  = ST_CHECK;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            t_in = '0;
            c_in = '0;
            f_in = '0;
            state_in = (seen_ff >= look) ? ST_ISSUE : ST_ADVANCE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            cmd.first = (t_ff == '0) && (c_ff == '0);
            if (int'(c_ff) + 1 == int'(ic)) begin
               c_in = '0;
               if (int'(t_ff) + 1 == int'(taps)) begin
                  t_in     = '0;
                  drain_in = 1'b0;
                  state_in = ST_DRAIN;
               end else begin
                  t_in = t_ff + RW'(1);
               end
            end else begin
               c_in = c_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            // Waiting here lets the last product reach the accumulator.
            drain_in = 1'b1;
            if (drain_ff) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.pos_last = pos_last;
               cmd.run_last = pos_last && (remain_ff == 4'd1);
               if (pos_last) begin
                  state_in = ST_ADVANCE;
               end else begin
                  f_in     = f_ff + FW'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            seen_in     = (seen_ff == 3'd7) ? 3'd7 : seen_ff + 3'd1;
            remain_in   = remain_ff - 4'd1;
            if (remain_ff == 4'd1) begin
               if (end_ff) begin
                  cmd.clear_all = 1'b1;
                  seen_in = '0;
               end
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         seen_ff     <= '0;
         remain_ff   <= '0;
         end_ff      <= 1'b0;
         t_ff        <= '0;
         c_ff        <= '0;
         f_ff        <= '0;
         drain_ff    <= 1'b0;
         tap_reg_ff  <= 3'd3;
         icnt_reg_ff <= 4'd1;
         ocnt_reg_ff <= 4'd1;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         remain_ff <= remain_in;
         end_ff    <= end_in;
         t_ff      <= t_in;
         c_ff      <= c_in;
         f_ff      <= f_in;
         drain_ff  <= drain_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_TAPS: tap_reg_ff  <= csr_data[2:0];
               CSR_ICNT: icnt_reg_ff <= csr_data;
               CSR_OCNT: ocnt_reg_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: design/conv1d_same_bias_relu_top.sv
// Load beats do not hold off the input. A sample beat that completes a position holds off the
// input until every position it retires is done; each emitted position is worked out filter
// by filter, as one shared multiply-accumulate unit does it all.
// An end-of-sequence beat retires the flushed positions the same way; a stalled result beat
// adds its wait. Reset is synchronous and active high; it clears the sample history at once.
module conv1d_same_bias_relu_top import c1d_pkg::*; #(
   parameter int MAX_TAPS = DEF_MAX_TAPS,
   parameter int MAX_IN   = DEF_MAX_IN,
   parameter int MAX_OUT  = DEF_MAX_OUT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [2:0]         req_tap_index,
   input  logic [2:0]         req_in_chan,
   input  logic [2:0]         req_out_chan,
   input  logic signed [15:0] req_sample_value,
   input  logic               req_sequence_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_filter_index,
   output logic [14:0]        rsp_result_value,
   output logic               rsp_position_last,
   output logic               rsp_run_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [3:0]         csr_data
);

   localparam int RW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
   localparam int FW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [RW-1:0] iss_tap, iss_row;
   logic [CW-1:0] iss_chan;
   logic [FW-1:0] iss_filt;

   c1d_ctrl #(.MAX_TAPS(MAX_TAPS), .MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_in_chan(req_in_chan), .req_sequence_end(req_sequence_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .cmd(cmd), .status(status),
      .iss_tap(iss_tap), .iss_row(iss_row), .iss_chan(iss_chan), .iss_filt(iss_filt)
   );

   c1d_dpath #(.MAX_TAPS(MAX_TAPS), .MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_tap_index(req_tap_index), .req_in_chan(req_in_chan),
      .req_out_chan(req_out_chan), .req_sample_value(req_sample_value),
      .iss_tap(iss_tap), .iss_row(iss_row), .iss_chan(iss_chan), .iss_filt(iss_filt),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_filter_index(rsp_filter_index),
      .rsp_result_value(rsp_result_value), .rsp_position_last(rsp_position_last),
      .rsp_run_last(rsp_run_last)
   );

endmodule

FILE: design/c1d_checker.sv
`include "assert_macros.svh"

module c1d_checker import c1d_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_filter_index,
   input logic [14:0] rsp_result_value,
   input logic        rsp_position_last,
   input logic        rsp_run_last
);

   // A stalled result beat keeps its payload.
   `CHK_ASSERT(rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_filter_index)))
   // The last result of a beat always closes a position.
   `CHK_NEVER(run_last_closes, clock, reset, rsp_valid && rsp_run_last && !rsp_position_last)
   // No result is pending right after reset.
   `CHK_ASSERT(rsp_reset, clock, 1'b0, reset |=> !rsp_valid)
   // Weight loads do not hold off the input.
   `CHK_ASSERT(load_one_cycle, clock, reset,
      (req_valid && req_ready && req_action == ACT_WEIGHT) |=> req_ready)

endmodule

bind conv1d_same_bias_relu_top c1d_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_filter_index(rsp_filter_index), .rsp_result_value(rsp_result_value),
   .rsp_position_last(rsp_position_last), .rsp_run_last(rsp_run_last)
);
